### sv/mm4_pkg.sv
// Shared types and constants for the 4x4 matrix multiplier.
// Used by mm4_mac and matrix4x4_multiply; depends on nothing else.
package mm4_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned PROD_W = 64;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctrl_t;

endpackage

### sv/mm4_mac.sv
// Shared multiply-accumulate unit: registered 32x32 signed multiply, then accumulate.
// Depends on mm4_pkg; the result is the sum shifted right by the fraction width and saturated.
module mm4_mac #(
  parameter int unsigned DIM = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mm4_pkg::mac_ctrl_t           ctrl_i,
  input  logic [mm4_pkg::DATA_W-1:0]   a_i,
  input  logic [mm4_pkg::DATA_W-1:0]   b_i,
  output logic                         done_o,
  output logic [mm4_pkg::DATA_W-1:0]   result_o
);
  import mm4_pkg::*;

  localparam int unsigned ACC_W = PROD_W + $clog2(DIM);
  localparam int unsigned SH_W  = ACC_W - FRAC_W;

  mac_ctrl_t                 prod_ctrl_q;
  logic                      done_q;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic signed [ACC_W-1:0]   acc_d, acc_q;
  logic signed [SH_W-1:0]    shifted;
  logic                      all_zero, all_one;

  assign prod_d = $signed(a_i) * $signed(b_i);
  assign acc_d  = prod_ctrl_q.first ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_ctrl_q <= '0;
      done_q      <= 1'b0;
    end else begin
      prod_ctrl_q <= ctrl_i;
      done_q      <= prod_ctrl_q.valid & prod_ctrl_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      prod_q <= prod_d;
    end
    if (prod_ctrl_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign shifted  = acc_q[ACC_W-1:FRAC_W];
  assign all_zero = (shifted[SH_W-1:DATA_W-1] == '0);
  assign all_one  = (shifted[SH_W-1:DATA_W-1] == '1);

  always_comb begin
    if (all_zero || all_one) begin
      result_o = shifted[DATA_W-1:0];
    end else if (shifted[SH_W-1]) begin
      result_o = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      result_o = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  assign done_o = done_q;

endmodule

### sv/matrix4x4_multiply.sv
// Top level of the matrix multiplier: load sequencer, element memories and output register.
// Depends on mm4_pkg and mm4_mac.
//
// The block takes 2*DIM*DIM signed Q16.16 elements, one per cycle while s_axis_tready_o
// is high: first matrix a, then matrix b, both column-major. It then drops ready and
// computes r = a * b one element at a time on a single shared multiply-accumulate unit,
// emitting each element in column-major order with tlast on the final one. For each result
// element DIM memory reads feed the multiply and accumulate stages and then the output
// register, which holds the element through any stall on the output. Results are the exact
// sum of products shifted right by 16 toward minus infinity and saturated to 32 bits.
module matrix4x4_multiply #(
  parameter int unsigned DIM = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // element[31:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // product[31:0], col_index[33:32], row_index[35:34]
  output logic        m_axis_tlast_o
);
  import mm4_pkg::*;

  localparam int unsigned CELLS = DIM * DIM;
  localparam int unsigned CA_W  = $clog2(CELLS);
  localparam int unsigned LD_W  = $clog2(2 * CELLS);
  localparam int unsigned IX_W  = $clog2(DIM);

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e                 state_d, state_q;
  logic [LD_W-1:0]        load_cnt_d, load_cnt_q;
  logic [IX_W-1:0]        col_d, col_q, row_d, row_q, k_d, k_q;
  logic                   issue_d, issue_q;
  logic                   out_vld_d, out_vld_q;
  logic                   in_fire, is_b;
  logic [CA_W-1:0]        wr_addr, rd_a_addr, rd_b_addr;
  logic [DATA_W-1:0]      mem_a [CELLS];
  logic [DATA_W-1:0]      mem_b [CELLS];
  logic [DATA_W-1:0]      rd_a_q, rd_b_q;
  mac_ctrl_t              mac_ctrl_d, mac_ctrl_q;
  logic                   mac_done;
  logic [DATA_W-1:0]      mac_result;
  logic [DATA_W-1:0]      out_prod_q;
  logic [1:0]             out_col_q, out_row_q;
  logic                   out_last_q;
  logic                   elem_last;

  assign in_fire   = s_axis_tvalid_i & s_axis_tready_o;
  assign is_b      = (load_cnt_q >= LD_W'(CELLS));
  assign wr_addr   = is_b ? CA_W'(load_cnt_q - LD_W'(CELLS)) : CA_W'(load_cnt_q);
  assign rd_a_addr = CA_W'(CA_W'(k_q) * CA_W'(DIM) + CA_W'(row_q));
  assign rd_b_addr = CA_W'(CA_W'(col_q) * CA_W'(DIM) + CA_W'(k_q));
  assign elem_last = (col_q == IX_W'(DIM - 1)) && (row_q == IX_W'(DIM - 1));

  assign mac_ctrl_d.valid = issue_q;
  assign mac_ctrl_d.first = (k_q == '0);
  assign mac_ctrl_d.last  = (k_q == IX_W'(DIM - 1));

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    col_d      = col_q;
    row_d      = row_q;
    k_d        = k_q;
    issue_d    = issue_q;
    out_vld_d  = out_vld_q;
    case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (load_cnt_q == LD_W'(2 * CELLS - 1)) begin
            load_cnt_d = '0;
            col_d      = '0;
            row_d      = '0;
            k_d        = '0;
            issue_d    = 1'b1;
            state_d    = ST_CALC;
          end else begin
            load_cnt_d = load_cnt_q + 1'b1;
          end
        end
      end
      ST_CALC: begin
        if (issue_q) begin
          if (k_q == IX_W'(DIM - 1)) begin
            issue_d = 1'b0;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
        if (mac_done) begin
          out_vld_d = 1'b1;
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (m_axis_tready_i) begin
          out_vld_d = 1'b0;
          if (elem_last) begin
            state_d = ST_LOAD;
          end else begin
            if (row_q == IX_W'(DIM - 1)) begin
              row_d = '0;
              col_d = col_q + 1'b1;
            end else begin
              row_d = row_q + 1'b1;
            end
            k_d     = '0;
            issue_d = 1'b1;
            state_d = ST_CALC;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      col_q      <= '0;
      row_q      <= '0;
      k_q        <= '0;
      issue_q    <= 1'b0;
      out_vld_q  <= 1'b0;
      mac_ctrl_q <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      col_q      <= col_d;
      row_q      <= row_d;
      k_q        <= k_d;
      issue_q    <= issue_d;
      out_vld_q  <= out_vld_d;
      mac_ctrl_q <= mac_ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && !is_b) begin
      mem_a[wr_addr] <= s_axis_tdata_i;
    end
    if (in_fire && is_b) begin
      mem_b[wr_addr] <= s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q <= mem_a[rd_a_addr];
    rd_b_q <= mem_b[rd_b_addr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CALC && mac_done) begin
      out_prod_q <= mac_result;
      out_col_q  <= 2'(col_q);
      out_row_q  <= 2'(row_q);
      out_last_q <= elem_last;
    end
  end

  mm4_mac #(
    .DIM (DIM)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl_q),
    .a_i      (rd_a_q),
    .b_i      (rd_b_q),
    .done_o   (mac_done),
    .result_o (mac_result)
  );

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'b0000, out_row_q, out_col_q, out_prod_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

### sim/matrix4x4_multiply_tb.sv
// Self-checking testbench for matrix4x4_multiply: streams pairs of 4x4 Q16.16 matrices
// and compares every result element against an in-bench fixed-point product.
// Depends on the matrix4x4_multiply RTL only.
module matrix4x4_multiply_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DIM        = 4;
  localparam int unsigned CELLS      = DIM * DIM;
  localparam int unsigned PAIR_ITEMS = 2 * CELLS;
  localparam int unsigned QUIET_MAX  = 3000;
  localparam logic signed [67:0] SAT_HI = 68'sd2147483647;
  localparam logic signed [67:0] SAT_LO = -68'sd2147483648;

  typedef struct packed {
    logic [31:0] product;
    logic [1:0]  col_index;
    logic [1:0]  row_index;
    logic        last;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;  // element[31:0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;       // product[31:0], col_index[33:32], row_index[35:34]
  logic        m_axis_tlast_o;

  result_t     expected_products[$];
  logic [31:0] loaded_elems[PAIR_ITEMS];
  int unsigned loaded_count = 0;
  int unsigned burst_left = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned error_count = 0;
  int unsigned results_checked = 0;
  int unsigned pairs_sent = 0;

  matrix4x4_multiply #(.DIM(DIM)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic queue_matrix_product();
    logic signed [67:0] acc;
    logic signed [67:0] lhs;
    logic signed [67:0] rhs;
    logic signed [67:0] shifted;
    result_t            res;
    for (int c = 0; c < DIM; c++) begin
      for (int row = 0; row < DIM; row++) begin
        acc = '0;
        for (int k = 0; k < DIM; k++) begin
          lhs = $signed(loaded_elems[k * DIM + row]);
          rhs = $signed(loaded_elems[CELLS + c * DIM + k]);
          acc = acc + lhs * rhs;
        end
        shifted = acc >>> 16;
        if (shifted > SAT_HI) begin
          shifted = SAT_HI;
        end else if (shifted < SAT_LO) begin
          shifted = SAT_LO;
        end
        res.product   = shifted[31:0];
        res.col_index = c[1:0];
        res.row_index = row[1:0];
        res.last      = (c == DIM - 1) && (row == DIM - 1);
        expected_products.push_back(res);
      end
    end
  endtask

  task automatic send_element(input logic [31:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    do @(posedge clk_i); while (!s_axis_tready_o);
    loaded_elems[loaded_count] = value;
    loaded_count++;
    if (loaded_count == PAIR_ITEMS) begin
      queue_matrix_product();
      loaded_count = 0;
      pairs_sent++;
    end
  endtask

  function automatic logic [31:0] random_element();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0, 1, 2: v = $urandom;
      3, 4:    v = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      5: begin
        case ($urandom_range(0, 5))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = 32'h0000_0000;
          3:       v = 32'hFFFF_FFFF;
          4:       v = 32'h0001_0000;
          default: v = 32'hFFFF_0000;
        endcase
      end
      6:       v = $urandom_range(0, 32'h0001_FFFF) - 32'h0001_0000;
      default: v = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
    endcase
    return v;
  endfunction

  task automatic send_random_pair();
    for (int i = 0; i < PAIR_ITEMS; i++) begin
      send_element(random_element());
    end
  endtask

  task automatic wait_for_results();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (expected_products.size() != 0) @(posedge clk_i);
  endtask

  // Rows of a and columns of b are chosen so that both saturation limits, identity
  // pass-through and floor rounding of negative sums all appear in one product.
  task automatic test_saturation_and_identity();
    logic [31:0] pair[PAIR_ITEMS];
    logic [31:0] row2[DIM];
    row2 = '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 32'hFFFF_FFFF};
    for (int k = 0; k < DIM; k++) begin
      pair[k * DIM + 0] = 32'h8000_0000;
      pair[k * DIM + 1] = 32'h7FFF_FFFF;
      pair[k * DIM + 2] = row2[k];
      pair[k * DIM + 3] = 32'h0000_0000;
    end
    for (int k = 0; k < DIM; k++) begin
      pair[CELLS + 0 * DIM + k] = 32'h7FFF_FFFF;
      pair[CELLS + 1 * DIM + k] = 32'h8000_0000;
      pair[CELLS + 2 * DIM + k] = (k == 2) ? 32'h0001_0000 : 32'h0000_0000;
      pair[CELLS + 3 * DIM + k] = 32'hFFFF_FFFF;
    end
    for (int i = 0; i < PAIR_ITEMS; i++) begin
      send_element(pair[i]);
    end
  endtask

  task automatic test_output_backpressure();
    hold_off_cycles = 400;
    send_random_pair();
    send_random_pair();
  endtask

  task automatic test_drain_between_passes();
    wait_for_results();
    send_random_pair();
    wait_for_results();
  endtask

  task automatic test_random_passes(input int unsigned count);
    for (int unsigned p = 0; p < count; p++) begin
      send_random_pair();
    end
  endtask

  initial begin : receiver
    int unsigned mode = 0;
    int unsigned span = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(8, 64);
      end
      span--;
      case (mode)
        0:       m_axis_tready_i <= 1'b1;
        1:       m_axis_tready_i <= 1'($urandom_range(0, 1));
        2:       m_axis_tready_i <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready_i <= (span % 3) != 0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    result_t exp_res;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_products.size() == 0) begin
        $error("unexpected result: tdata %h, tlast %b", m_axis_tdata_o, m_axis_tlast_o);
        error_count++;
      end else begin
        exp_res = expected_products.pop_front();
        results_checked++;
        if (m_axis_tdata_o[31:0] !== exp_res.product) begin
          $error("product mismatch: expected %h, got %h",
                 exp_res.product, m_axis_tdata_o[31:0]);
          error_count++;
        end
        if (m_axis_tdata_o[33:32] !== exp_res.col_index) begin
          $error("col_index mismatch: expected %0d, got %0d",
                 exp_res.col_index, m_axis_tdata_o[33:32]);
          error_count++;
        end
        if (m_axis_tdata_o[35:34] !== exp_res.row_index) begin
          $error("row_index mismatch: expected %0d, got %0d",
                 exp_res.row_index, m_axis_tdata_o[35:34]);
          error_count++;
        end
        if (m_axis_tlast_o !== exp_res.last) begin
          $error("last mismatch: expected %b, got %b", exp_res.last, m_axis_tlast_o);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout after %0d cycles without a transaction.", QUIET_MAX);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_saturation_and_identity();
    test_output_backpressure();
    test_drain_between_passes();
    test_random_passes(9);
    wait_for_results();
    repeat (40) @(posedge clk_i);
    $display("Checked %0d result elements from %0d matrix pairs.", results_checked, pairs_sent);
    $display("Covered saturation, identity, output hold-off, drained pauses and random bursts.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
